// ----- src/stktr_pkg.sv -----
// Shared types, codes and sizes of the streaming top-K tracker.
package stktr_pkg;

  localparam int MAX_SLOTS = 64;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int KEY_W     = 31;
  localparam int ID_W      = 16;
  localparam int SIDE_W    = 16;
  localparam int CFG_W     = 7;

  localparam logic [CFG_W-1:0] K_RESET = CFG_W'(10);

  localparam logic [1:0] KIND_RECORD  = 2'd0;
  localparam logic [1:0] KIND_READOUT = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_READOUT = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [KEY_W-1:0]  rank_key;
    logic [ID_W-1:0]   record_id;
    logic [SIDE_W-1:0] side_count;
    logic              is_deleted;
    logic              is_excluded;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]  out_key;
    logic [ID_W-1:0]   out_id;
    logic [SIDE_W-1:0] out_side_count;
    logic              empty_list;
    logic              last_entry;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [KEY_W-1:0]  key;
    logic [ID_W-1:0]   id;
    logic [SIDE_W-1:0] side;
  } cmd_t;

endpackage

// ----- src/stktr_front.sv -----
// Front end: accepts requests, drops skipped records, queues table commands.
module stktr_front import stktr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  in_item_t req,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       keep;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;

  always_comb begin
    keep = 1'b0;
    cmd_in.op   = OP_INSERT;
    cmd_in.key  = req.rank_key;
    cmd_in.id   = req.record_id;
    cmd_in.side = req.side_count;
    case (req.kind)
      KIND_RECORD: begin
        keep = !req.is_deleted && !req.is_excluded;
        cmd_in.op = OP_INSERT;
      end
      KIND_READOUT: begin
        keep = 1'b1;
        cmd_in.op = OP_READOUT;
      end
      KIND_CLEAR: begin
        keep = 1'b1;
        cmd_in.op = OP_CLEAR;
      end
      default: keep = 1'b0;
    endcase
  end

  assign req_ready = cnt != 2'd2;
  assign cmd_valid = cnt != 2'd0;
  assign cmd       = q[rp];
  assign push      = req_valid && req_ready && keep;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- src/stktr_back.sv -----
// Back end: slot memory, minimum scan for inserts, ranked readout passes.
module stktr_back import stktr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] k,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  cmd_t             cmd,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output out_item_t        rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ID_W-1:0]   id;
    logic [SIDE_W-1:0] side;
  } slot_t;

  slot_t              mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] valid;
  slot_t              rd_data;
  logic               rd_vld;
  logic [SLOT_W-1:0]  rd_addr;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  slot_t              wr_data;
  logic               clr;

  logic [1:0]         state;
  logic [CNT_W-1:0]   cnt;
  logic               proc_vld;
  logic [SLOT_W-1:0]  proc_idx;
  slot_t              new_item;

  logic [KEY_W-1:0]   least;
  logic [SLOT_W-1:0]  which;

  logic               best_found;
  slot_t              best;
  logic [SLOT_W-1:0]  best_idx;
  logic               have_pend;
  slot_t              pend;
  logic [SLOT_W-1:0]  pend_idx;

  logic [KEY_W-1:0]   elem_key;
  logic               scan_end;
  logic               rsp_free;
  logic               cand;

  assign rd_addr   = cnt[SLOT_W-1:0];
  assign elem_key  = rd_vld ? rd_data.key : '0;
  assign scan_end  = (cnt == k) && !proc_vld;
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign cmd_ready = state == S_IDLE;
  assign cand      = (elem_key != '0) &&
                     (!have_pend || (elem_key < pend.key) ||
                      ((elem_key == pend.key) && (proc_idx > pend_idx)));

  assign wr_en   = (state == S_INS) && scan_end && (new_item.key > least);
  assign wr_addr = which;
  assign wr_data = new_item;
  assign clr     = cmd_valid && cmd_ready && (cmd.op == OP_CLEAR);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
    rd_vld  <= valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state != S_IDLE) begin
      if (cnt < k) begin
        cnt <= cnt + CNT_W'(1);
      end
      proc_idx <= cnt[SLOT_W-1:0];
    end
    if (cmd_valid && cmd_ready) begin
      new_item.key  <= cmd.key;
      new_item.id   <= cmd.id;
      new_item.side <= cmd.side;
    end
    if ((state == S_INS) && proc_vld) begin
      if ((proc_idx == '0) || (elem_key < least)) begin
        least <= elem_key;
        which <= proc_idx;
      end
    end
    if ((state == S_RD) && proc_vld && cand) begin
      if (!best_found || (elem_key > best.key)) begin
        best.key  <= elem_key;
        best.id   <= rd_data.id;
        best.side <= rd_data.side;
        best_idx  <= proc_idx;
      end
    end
    if ((state == S_RD) && scan_end && rsp_free && best_found) begin
      pend     <= best;
      pend_idx <= best_idx;
      cnt      <= '0;
    end
    if (state == S_IDLE) begin
      cnt <= '0;
    end
    if (rsp_free && (state == S_RD) && scan_end) begin
      rsp.out_key        <= have_pend ? pend.key : '0;
      rsp.out_id         <= have_pend ? pend.id : '0;
      rsp.out_side_count <= have_pend ? pend.side : '0;
      rsp.empty_list     <= !have_pend;
      rsp.last_entry     <= !best_found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      proc_vld   <= 1'b0;
      best_found <= 1'b0;
      have_pend  <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      proc_vld <= (state != S_IDLE) && (cnt < k);
      case (state)
        S_IDLE: begin
          proc_vld   <= 1'b0;
          best_found <= 1'b0;
          have_pend  <= 1'b0;
          if (cmd_valid) begin
            case (cmd.op)
              OP_INSERT:  state <= S_INS;
              OP_READOUT: state <= S_RD;
              default:    state <= S_IDLE;
            endcase
          end
        end
        S_INS: begin
          if (scan_end) begin
            state <= S_IDLE;
          end
        end
        S_RD: begin
          if (proc_vld && cand) begin
            best_found <= 1'b1;
          end
          if (scan_end && rsp_free) begin
            best_found <= 1'b0;
            proc_vld   <= 1'b0;
            if (best_found) begin
              have_pend <= 1'b1;
              if (have_pend) begin
                rsp_valid <= 1'b1;
              end
            end else begin
              rsp_valid <= 1'b1;
              have_pend <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/streaming_top_k_tracker.sv -----
// Top level of the streaming top-K tracker: K register, front end, back end.
//
//  channel | direction | payload    | accepted when
//  req     | in        | in_item_t  | req_valid && req_ready
//  rsp     | out       | out_item_t | rsp_valid && rsp_ready
//  cfg     | in        | cfg_data   | cfg_valid && cfg_ready
//
// A record holds the back end for the accept cycle, K slot memory reads at one a
// cycle, the wait for the last read data, then the write. A readout of n entries
// takes the accept cycle and (n+1) scans of the K slots; a clear is done in the
// accept cycle. A two-entry command queue lets requests enter while the back end works.
// Reset is synchronous and clears the slot valid bits at once. A stalled response
// holds the readout scan.
module streaming_top_k_tracker import stktr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  in_item_t         req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output out_item_t        rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [CFG_W-1:0] entries_in_use;
  logic [CNT_W-1:0] k;
  logic             cmd_valid;
  logic             cmd_ready;
  cmd_t             cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= K_RESET;
    end else if (cfg_valid && cfg_ready) begin
      entries_in_use <= cfg_data;
    end
  end

  always_comb begin
    if (entries_in_use == '0) begin
      k = CNT_W'(1);
    end else if (entries_in_use > CFG_W'(MAX_SLOTS)) begin
      k = CNT_W'(MAX_SLOTS);
    end else begin
      k = entries_in_use[CNT_W-1:0];
    end
  end

  stktr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  stktr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .k         (k),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
